>>> rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// Duration text parser package
// Shared types, character codes and unit constants for the parser blocks.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Field and datapath widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SecW    = 64;
  localparam int unsigned MagW    = 63;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned WeightW = 17;
  localparam int unsigned NumUnits = 4;

  // Default depth of the queue between the classifier and the executor.
  localparam int unsigned QueueDepthDefault = 2;

  // Largest magnitude a total may reach.
  localparam logic [MagW-1:0] MaxMag = {MagW{1'b1}};

  // Character codes.
  localparam logic [ByteW-1:0] ChEnd   = 8'h00;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChDay   = 8'h64;
  localparam logic [ByteW-1:0] ChHour  = 8'h68;
  localparam logic [ByteW-1:0] ChMin   = 8'h6d;
  localparam logic [ByteW-1:0] ChSec   = 8'h73;

  // Seconds per unit.
  localparam logic [WeightW-1:0] WeightDay  = 17'd86400;
  localparam logic [WeightW-1:0] WeightHour = 17'd3600;
  localparam logic [WeightW-1:0] WeightMin  = 17'd60;
  localparam logic [WeightW-1:0] WeightSec  = 17'd1;

  // Largest count of each unit whose product still fits.
  localparam logic [MagW-1:0] LimitDay  = MagW'(64'(MaxMag) / 64'd86400);
  localparam logic [MagW-1:0] LimitHour = MagW'(64'(MaxMag) / 64'd3600);
  localparam logic [MagW-1:0] LimitMin  = MagW'(64'(MaxMag) / 64'd60);
  localparam logic [MagW-1:0] LimitSec  = MaxMag;

  // Kind of a classified text byte.
  typedef enum logic [2:0] {
    KindDigit = 3'd0,
    KindMinus = 3'd1,
    KindUnit  = 3'd2,
    KindEnd   = 3'd3,
    KindOther = 3'd4
  } kind_e;

  // Unit letters; the code is also the bit position in the seen mask.
  typedef enum logic [1:0] {
    UnitDay  = 2'd0,
    UnitHour = 2'd1,
    UnitMin  = 2'd2,
    UnitSec  = 2'd3
  } unit_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    kind_e              kind;
    logic [DigitW-1:0]  digit;
    unit_e              unit;
  } dtp_item_t;

  // Seconds per unit letter.
  function automatic logic [WeightW-1:0] unit_weight(unit_e u);
    logic [WeightW-1:0] w;
    unique case (u)
      UnitDay:  w = WeightDay;
      UnitHour: w = WeightHour;
      UnitMin:  w = WeightMin;
      default:  w = WeightSec;
    endcase
    return w;
  endfunction

  // Overflow bound on the count for each unit letter.
  function automatic logic [MagW-1:0] unit_limit(unit_e u);
    logic [MagW-1:0] l;
    unique case (u)
      UnitDay:  l = LimitDay;
      UnitHour: l = LimitHour;
      UnitMin:  l = LimitMin;
      default:  l = LimitSec;
    endcase
    return l;
  endfunction

endpackage

>>> rtl/duration_text_parser_core.sv
// ----------------------------------------------------------------------------
// Duration text parser core
// Parses compact duration text such as "-1h2m3s" into signed seconds.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one text byte per word; a zero byte ends the
//   string. For each zero byte the master stream gives one word: the signed
//   seconds in tdata and a status bit in tuser (0 ok, 1 error, seconds 0).
//   Other bytes give no output word.
// Throughput: one byte per cycle while no zero byte waits on a full result
//   register. The executor updates the digit value, the per-unit products
//   and the total for each byte. A zero byte is written into the queue;
//   the executor then pops it and loads the result register, which drives
//   the master side.
// Stalls: the result register holds its word while tready is low. Bytes
//   keep flowing into the executor; only the next zero byte waits, and the
//   queue then fills and drops s_axis_tready.
// Reset: the parse state, the queue and the result valid flag are cleared;
//   the block is ready for a new string right after reset is released.
// ----------------------------------------------------------------------------
module duration_text_parser_core #(
  parameter int unsigned QueueDepth = dtp_pkg::QueueDepthDefault  // 2 or more
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [dtp_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] text_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [dtp_pkg::SecW-1:0] m_axis_tdata,   // [63:0] seconds
  output logic                     m_axis_tuser    // [0] status
);
  import dtp_pkg::*;

  logic      front_valid, front_ready;
  dtp_item_t front_item;
  logic      back_valid, back_ready;
  dtp_item_t back_item;

  // Byte classification.
  dtp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid_o  (front_valid),
    .item_ready_i  (front_ready),
    .item_o        (front_item)
  );

  // Queue between classification and execution.
  dtp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  // Parse execution and result register.
  dtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> rtl/dtp_front.sv
// ----------------------------------------------------------------------------
// Duration text parser front end
// Classifies each incoming text byte into digit, sign, unit, end or other.
// ----------------------------------------------------------------------------
module dtp_front (
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [dtp_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] text_byte
  output logic                      item_valid_o,
  input  logic                      item_ready_i,
  output dtp_pkg::dtp_item_t        item_o
);
  import dtp_pkg::*;

  // The front never holds a word; it stalls only when the queue is full.
  assign s_axis_tready = item_ready_i;
  assign item_valid_o  = s_axis_tvalid;

  // Decode the character class and, for digits and units, its value.
  always_comb begin
    item_o.digit = s_axis_tdata[DigitW-1:0];
    item_o.unit  = UnitSec;
    item_o.kind  = KindOther;
    unique case (s_axis_tdata) inside
      ChEnd:           item_o.kind = KindEnd;
      [ChZero:ChNine]: item_o.kind = KindDigit;
      ChMinus:         item_o.kind = KindMinus;
      ChDay: begin
        item_o.kind = KindUnit;
        item_o.unit = UnitDay;
      end
      ChHour: begin
        item_o.kind = KindUnit;
        item_o.unit = UnitHour;
      end
      ChMin: begin
        item_o.kind = KindUnit;
        item_o.unit = UnitMin;
      end
      ChSec: begin
        item_o.kind = KindUnit;
        item_o.unit = UnitSec;
      end
      default:         item_o.kind = KindOther;
    endcase
  end

endmodule

>>> rtl/dtp_queue.sv
// ----------------------------------------------------------------------------
// Duration text parser queue
// Small FIFO of classified bytes between the front end and the executor.
// ----------------------------------------------------------------------------
module dtp_queue #(
  parameter int unsigned Depth = dtp_pkg::QueueDepthDefault  // 2 or more
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  dtp_pkg::dtp_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output dtp_pkg::dtp_item_t pop_item_o
);
  import dtp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dtp_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the count says which entries hold a word.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/dtp_back.sv
// ----------------------------------------------------------------------------
// Duration text parser executor
// Runs the parse state for each classified byte and registers the result.
// ----------------------------------------------------------------------------
module dtp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  dtp_pkg::dtp_item_t       item_i,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [dtp_pkg::SecW-1:0] m_axis_tdata,   // [63:0] seconds
  output logic                     m_axis_tuser    // [0] status
);
  import dtp_pkg::*;

  typedef enum logic [3:0] {
    PhStart  = 4'b0001,
    PhSign   = 4'b0010,
    PhDigits = 4'b0100,
    PhUnit   = 4'b1000
  } phase_e;

  localparam int unsigned WideW = MagW + 4;
  localparam int unsigned PartW = DigitW + WeightW;

  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic                  lone_q, lone_d;
  logic                  err_q, err_d;
  logic [NumUnits-1:0]   units_q, units_d;
  logic [MagW-1:0]       digit_q, digit_d;
  logic [MagW-1:0]       total_q, total_d;
  // Running product of the digit value with each unit weight, modulo 2^63.
  logic [MagW-1:0]       prod_q [NumUnits];
  logic [MagW-1:0]       prod_d [NumUnits];
  logic                  out_valid_q, out_valid_d;
  logic [SecW-1:0]       out_secs_q, out_secs_d;
  logic                  out_status_q, out_status_d;

  logic                  out_free, fire, is_end;
  logic [WideW-1:0]      acc_wide;
  logic                  acc_ovf;
  logic [MagW-1:0]       start_prod [NumUnits];
  logic [MagW-1:0]       step_prod  [NumUnits];
  logic [NumUnits-1:0]   unit_bit;
  logic                  unit_rep, prod_ovf, sum_ovf, close_err;
  logic [MagW:0]         sum_wide;
  logic                  res_ok;
  logic [SecW-1:0]       res_secs;

  // An end byte needs the result register free; other bytes never wait.
  assign out_free     = !out_valid_q || m_axis_tready;
  assign is_end       = (item_i.kind == KindEnd);
  assign item_ready_o = !is_end || out_free;
  assign fire         = item_valid_i && item_ready_o;

  // Digit accumulation: value * 10 + digit, with overflow from the top bits.
  assign acc_wide = (WideW'(digit_q) << 3) + (WideW'(digit_q) << 1) + WideW'(item_i.digit);
  assign acc_ovf  = |acc_wide[WideW-1:MagW];

  // Per-unit products for a fresh digit run and for one more digit.
  always_comb begin
    for (int i = 0; i < NumUnits; i++) begin
      start_prod[i] = MagW'(PartW'(item_i.digit) * PartW'(unit_weight(unit_e'(2'(i)))));
      step_prod[i]  = (prod_q[i] << 3) + (prod_q[i] << 1) + start_prod[i];
    end
  end

  // Closing a number with its unit letter.
  assign unit_bit  = NumUnits'(1) << item_i.unit;
  assign unit_rep  = |(units_q & unit_bit);
  assign prod_ovf  = digit_q > unit_limit(item_i.unit);
  assign sum_wide  = {1'b0, total_q} + {1'b0, prod_q[item_i.unit]};
  assign sum_ovf   = sum_wide[MagW];
  assign close_err = (item_i.kind != KindUnit) || unit_rep || prod_ovf || sum_ovf;

  // Result for the end of the string.
  always_comb begin
    res_ok = !err_q && ((phase_q == PhUnit) || ((phase_q == PhDigits) && lone_q));
    if (!res_ok) begin
      res_secs = '0;
    end else if (phase_q == PhUnit && neg_q) begin
      res_secs = '0 - {1'b0, total_q};
    end else if (phase_q == PhUnit) begin
      res_secs = {1'b0, total_q};
    end else begin
      res_secs = '0;
    end
  end

  // Parse state update.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    lone_d  = lone_q;
    err_d   = err_q;
    units_d = units_q;
    digit_d = digit_q;
    total_d = total_q;
    prod_d  = prod_q;
    if (fire && is_end) begin
      phase_d = PhStart;
      neg_d   = 1'b0;
      lone_d  = 1'b0;
      err_d   = 1'b0;
      units_d = '0;
      digit_d = '0;
      total_d = '0;
      for (int i = 0; i < NumUnits; i++) begin
        prod_d[i] = '0;
      end
    end else if (fire && !err_q) begin
      unique case (phase_q)
        PhStart, PhSign: begin
          if (phase_q == PhStart && item_i.kind == KindMinus) begin
            neg_d   = 1'b1;
            phase_d = PhSign;
          end else if (item_i.kind == KindDigit) begin
            digit_d = MagW'(item_i.digit);
            prod_d  = start_prod;
            lone_d  = (item_i.digit == '0);
            phase_d = PhDigits;
          end else begin
            err_d = 1'b1;
          end
        end
        PhDigits: begin
          lone_d = 1'b0;
          if (item_i.kind == KindDigit) begin
            if (acc_ovf) begin
              err_d = 1'b1;
            end else begin
              digit_d = acc_wide[MagW-1:0];
              prod_d  = step_prod;
            end
          end else if (close_err) begin
            err_d = 1'b1;
          end else begin
            units_d = units_q | unit_bit;
            total_d = sum_wide[MagW-1:0];
            phase_d = PhUnit;
          end
        end
        PhUnit: begin
          if (item_i.kind == KindDigit) begin
            digit_d = MagW'(item_i.digit);
            prod_d  = start_prod;
            phase_d = PhDigits;
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  // Result register; a new result loads as the old one leaves.
  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_secs_d   = out_secs_q;
    out_status_d = out_status_q;
    if (fire && is_end) begin
      out_valid_d  = 1'b1;
      out_secs_d   = res_secs;
      out_status_d = !res_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      neg_q       <= 1'b0;
      lone_q      <= 1'b0;
      err_q       <= 1'b0;
      units_q     <= '0;
      digit_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumUnits; i++) begin
        prod_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      lone_q      <= lone_d;
      err_q       <= err_d;
      units_q     <= units_d;
      digit_q     <= digit_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      prod_q      <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_secs_q   <= out_secs_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_secs_q;
  assign m_axis_tuser  = out_status_q;

endmodule

>>> rtl/dtp_checker.sv
// ----------------------------------------------------------------------------
// Duration text parser checker
// Port-level assertions on the parser core, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [dtp_pkg::SecW-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);
  import dtp_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // An error result always carries zero seconds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero seconds");

  // Totals are limited to 2^63-1, so the most negative value never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != {1'b1, {(SecW-1){1'b0}}})
    else $error("result magnitude out of range");

  // No result word is pending right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With the result register empty the executor drains the queue, so the
  // input is ready again on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tvalid |=> s_axis_tready)
    else $error("input stalled with the result register empty");

endmodule

bind duration_text_parser_core dtp_checker u_dtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
